// File: rtl/xoshiro_pkg.sv
// shared types, constants and helper functions for the xoshiro256++ generator
`timescale 1ns / 1ps

package xoshiro_pkg;

    typedef logic [63:0] word_t;

    localparam int unsigned WORD_W      = 64;
    localparam int unsigned NUM_WORDS   = 4;
    localparam int unsigned WIDX_W      = 2;
    localparam int unsigned FRAC53_W    = 53;
    localparam int unsigned FRAC24_W    = 24;
    localparam int unsigned CMD_W       = 1;
    localparam int unsigned OUT_BITS    = WORD_W + FRAC53_W + FRAC24_W;
    localparam int unsigned OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_PAD_W   = OUT_DATA_W - OUT_BITS;

    // command codes carried on the input tuser
    localparam logic [CMD_W-1:0] CMD_NEXT   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_RESEED = 1'b1;

    localparam word_t SM_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam word_t SM_MUL1  = 64'hbf58_476d_1ce4_e5b9;
    localparam word_t SM_MUL2  = 64'h94d0_49bb_1331_11eb;

    // partial product selection for the shared 32x32 multiplier
    localparam logic [1:0] PP_LO_LO = 2'd0;
    localparam logic [1:0] PP_HI_LO = 2'd1;
    localparam logic [1:0] PP_LO_HI = 2'd2;

    typedef struct packed {
        logic              load_seed;
        logic              step_acc;
        logic              mul_en;
        logic [1:0]        mul_phase;
        logic              mul_sel;
        logic              mix_xor;
        logic              write_word;
        logic [WIDX_W-1:0] word_idx;
        logic              gen_next;
    } dp_cmd_t;

    function automatic word_t rotl64(input word_t v, input int unsigned amt);
        rotl64 = (v << amt) | (v >> (WORD_W - amt));
    endfunction

    // full splitmix64 finaliser, used only on constants at elaboration
    function automatic word_t sm_mix(input word_t v);
        word_t z;
        z = v;
        z = (z ^ (z >> 30)) * SM_MUL1;
        z = (z ^ (z >> 27)) * SM_MUL2;
        sm_mix = z ^ (z >> 31);
    endfunction

    // state after reset: splitmix64 expansion of seed zero
    localparam word_t SEED0_W0 = sm_mix(word_t'(SM_GAMMA * 64'd1));
    localparam word_t SEED0_W1 = sm_mix(word_t'(SM_GAMMA * 64'd2));
    localparam word_t SEED0_W2 = sm_mix(word_t'(SM_GAMMA * 64'd3));
    localparam word_t SEED0_W3 = sm_mix(word_t'(SM_GAMMA * 64'd4));

endpackage

// File: rtl/xoshiro_ctrl.sv
// controller: stream handshake and the reseed sequencer
`timescale 1ns / 1ps

module xoshiro_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [xoshiro_pkg::CMD_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output xoshiro_pkg::dp_cmd_t          cmd
);
    import xoshiro_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADD  = 3'd1;
    localparam logic [2:0] ST_MUL0 = 3'd2;
    localparam logic [2:0] ST_MUL1 = 3'd3;
    localparam logic [2:0] ST_MUL2 = 3'd4;
    localparam logic [2:0] ST_MIX  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic              sel_reg, sel_next;
    logic [WIDX_W-1:0] cnt_reg, cnt_next;
    logic              valid_reg, valid_next;
    logic              accept;

    assign s_tready = (state_reg == ST_IDLE) && (!valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mul_sel  = sel_reg;
        cmd.word_idx = cnt_reg;

        // output register: filled by a next command, emptied by a transfer
        if (accept && (s_tuser == CMD_NEXT))
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == CMD_RESEED)
                    begin
                        cmd.load_seed = 1'b1;
                        sel_next      = 1'b0;
                        cnt_next      = '0;
                        state_next    = ST_ADD;
                    end
                    else
                    begin
                        cmd.gen_next = 1'b1;
                    end
                end
            end
            ST_ADD:
            begin
                cmd.step_acc = 1'b1;
                state_next   = ST_MUL0;
            end
            ST_MUL0:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = PP_LO_LO;
                state_next    = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = PP_HI_LO;
                state_next    = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = PP_LO_HI;
                state_next    = ST_MIX;
            end
            ST_MIX:
            begin
                if (!sel_reg)
                begin
                    cmd.mix_xor = 1'b1;
                    sel_next    = 1'b1;
                    state_next  = ST_MUL0;
                end
                else
                begin
                    cmd.write_word = 1'b1;
                    sel_next       = 1'b0;
                    cnt_next       = cnt_reg + 1'b1;
                    // last state word written ends the reseed
                    state_next     = (cnt_reg == WIDX_W'(NUM_WORDS - 1)) ? ST_IDLE : ST_ADD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// File: rtl/xoshiro_datapath.sv
// datapath: generator state, splitmix64 seeding arithmetic and output register
`timescale 1ns / 1ps

module xoshiro_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  xoshiro_pkg::dp_cmd_t               cmd,
    input  xoshiro_pkg::word_t                 seed,
    output logic [xoshiro_pkg::OUT_DATA_W-1:0] out_data
);
    import xoshiro_pkg::*;

    word_t gen_words_reg [NUM_WORDS];
    word_t acc_reg;
    word_t z_reg;
    word_t prod_reg, prod_next;
    word_t out_word_reg;

    word_t acc_sum;
    word_t mul_const;
    logic [31:0] mul_a, mul_b;
    word_t mul_out;

    word_t w0, w1, w2, w3;
    word_t gen_out;
    word_t t2, t3;

    assign w0 = gen_words_reg[0];
    assign w1 = gen_words_reg[1];
    assign w2 = gen_words_reg[2];
    assign w3 = gen_words_reg[3];

    // xoshiro256++ output and state update
    assign gen_out = rotl64(w0 + w3, 23) + w0;
    assign t2      = w2 ^ w0;
    assign t3      = w3 ^ w1;

    assign acc_sum = acc_reg + SM_GAMMA;

    // low 64 bits of z * constant from three 32x32 partial products
    assign mul_const = cmd.mul_sel ? SM_MUL2 : SM_MUL1;

    always_comb
    begin
        unique case (cmd.mul_phase)
            PP_HI_LO:
            begin
                mul_a = z_reg[63:32];
                mul_b = mul_const[31:0];
            end
            PP_LO_HI:
            begin
                mul_a = z_reg[31:0];
                mul_b = mul_const[63:32];
            end
            default:
            begin
                mul_a = z_reg[31:0];
                mul_b = mul_const[31:0];
            end
        endcase
        mul_out = {32'd0, mul_a} * {32'd0, mul_b};
        if (cmd.mul_phase == PP_LO_LO)
        begin
            prod_next = mul_out;
        end
        else
        begin
            prod_next = prod_reg + {mul_out[31:0], 32'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_seed)
        begin
            acc_reg <= seed;
        end
        else if (cmd.step_acc)
        begin
            acc_reg <= acc_sum;
        end

        if (cmd.step_acc)
        begin
            z_reg <= acc_sum ^ (acc_sum >> 30);
        end
        else if (cmd.mix_xor)
        begin
            z_reg <= prod_reg ^ (prod_reg >> 27);
        end

        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end

        if (cmd.gen_next)
        begin
            out_word_reg <= gen_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_words_reg[0] <= SEED0_W0;
            gen_words_reg[1] <= SEED0_W1;
            gen_words_reg[2] <= SEED0_W2;
            gen_words_reg[3] <= SEED0_W3;
        end
        else if (cmd.write_word)
        begin
            gen_words_reg[cmd.word_idx] <= prod_reg ^ (prod_reg >> 31);
        end
        else if (cmd.gen_next)
        begin
            gen_words_reg[0] <= w0 ^ t3;
            gen_words_reg[1] <= w1 ^ t2;
            gen_words_reg[2] <= t2 ^ (w1 << 17);
            gen_words_reg[3] <= rotl64(t3, 45);
        end
    end

    assign out_data = {{OUT_PAD_W{1'b0}},
                       out_word_reg[WORD_W-1 -: FRAC24_W],
                       out_word_reg[WORD_W-1 -: FRAC53_W],
                       out_word_reg};

endmodule

// File: rtl/xoshiro256pp_generator_unit.sv
// top level of the xoshiro256++ generator with splitmix64 reseeding
// next command: result in the output register in the cycle after the transfer,
//   one new value per cycle while the output side keeps taking them
// reseed command: busy for ADD, MUL0-2, MIX, MUL0-2, MIX on each of 4 words, no result
// reset: asynchronous, state words load the splitmix64 expansion of seed zero
`timescale 1ns / 1ps

module xoshiro256pp_generator_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [63:0]                        s_tdata,  // seed_value
    input  logic [xoshiro_pkg::CMD_W-1:0]      s_tuser,  // command
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [xoshiro_pkg::OUT_DATA_W-1:0] m_tdata   // random_word, fraction53, fraction24
);
    import xoshiro_pkg::*;

    dp_cmd_t cmd;

    xoshiro_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    xoshiro_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .seed     (s_tdata),
        .out_data (m_tdata)
    );

endmodule

// File: rtl/xoshiro_checker.sv
// port-level checks for the xoshiro256++ generator, bound to the top level
`timescale 1ns / 1ps

module xoshiro_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [xoshiro_pkg::CMD_W-1:0]      s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [xoshiro_pkg::OUT_DATA_W-1:0] m_tdata
);
    import xoshiro_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a next transfer is followed by a result
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_NEXT) |=> m_tvalid)
        else $error("next command gave no result");

    // a reseed keeps the input side busy
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_RESEED) |=> !s_tready)
        else $error("input accepted during reseed");

    // results appear only after a next transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == CMD_NEXT)))
        else $error("result without a next command");

    // fractions are the top bits of the word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[116:64] == m_tdata[63:11]) && (m_tdata[140:117] == m_tdata[63:40]))
        else $error("fraction fields disagree with random word");

endmodule

bind xoshiro256pp_generator_unit xoshiro_checker u_checker (.*);
